// ----- src/nfra_pkg.sv -----
// Shared types and constants for the next-free room allocator.
// No dependencies.
package nfra_pkg;

    localparam int ROOM_W    = 11;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    typedef logic [ROOM_W-1:0] t_room;
    typedef logic [BIT_W-1:0]  t_bit;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_CK0,
        ST_RD1,
        ST_CK1
    } t_state;

endpackage

// ----- src/nfra_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nfra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/next_free_room_allocator_core.sv -----
// Next-free room allocator: occupancy bitmap in a word RAM plus per-word full flags.
// Depends on nfra_pkg and nfra_ram.
// A request above the limit gets a registered reject result. Otherwise the requested
// word is read and checked; if it holds no free room, the next non-full word is read
// and checked. No new request is taken until the word RAM read-check loop is done.
// Reset (synchronous, active low): all rooms free via per-word valid bits, room_count 1024.
// The receiver cannot stall: each result is a one-cycle strobe.
module next_free_room_allocator_core #(
    parameter int ROOMS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  nfra_pkg::t_room       i_requested_room,
    output logic                  o_result_valid,
    output nfra_pkg::t_room       o_assigned_room,
    output logic                  o_none_free,
    input  logic                  i_cfg_we,
    input  nfra_pkg::t_room       i_cfg_wdata
);
    import nfra_pkg::*;

    localparam int USED_ROOMS = (ROOMS < 2047) ? ROOMS : 2047;
    localparam int WORDS      = (USED_ROOMS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam t_room ROOM_CAP = ROOM_W'(USED_ROOMS);
    localparam t_room ROOM_CNT_RST = ROOM_W'(1024);

    t_state r_state, n_state;

    t_room           r_room_count;
    t_room           r_req;
    t_room           r_limit;
    logic [WW-1:0]   r_w0, r_wl, r_word, r_cand;
    logic            r_cand_ok;
    logic [WORDS-1:0] r_valid, r_full;
    logic            r_res_stb, r_res_none;
    t_room           r_res_room;

    t_room           req1, lim, req1_m1, lim_m1, r_req_m1, r_lim_m1;
    logic            reject, accept;
    logic [WW-1:0]   cand;
    logic            cand_ok;

    logic                 ram_re, ram_we;
    logic [WW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata, word_data, word_new;
    t_bit                 lo_bit, hi_bit, free_bit;
    logic                 found;
    logic                 checking;
    t_room                found_room;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign req1    = (i_requested_room == '0) ? ROOM_W'(1) : i_requested_room;
    assign lim     = (r_room_count < ROOM_CAP) ? r_room_count : ROOM_CAP;
    assign reject  = req1 > lim;
    assign req1_m1 = req1 - ROOM_W'(1);
    assign lim_m1  = lim - ROOM_W'(1);
    assign r_req_m1 = r_req - ROOM_W'(1);
    assign r_lim_m1 = r_limit - ROOM_W'(1);

    // Lowest non-full word above the first word, within the limit.
    always_comb begin
        cand    = '0;
        cand_ok = 1'b0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (i > int'(r_w0) && i <= int'(r_wl) && !r_full[i]) begin
                cand    = WW'(i);
                cand_ok = 1'b1;
            end
        end
    end

    // Free-bit search in the word just read.
    assign word_data = r_valid[r_word] ? ram_rdata : '0;
    assign lo_bit    = (r_word == r_w0) ? r_req_m1[BIT_W-1:0] : '0;
    assign hi_bit    = (r_word == r_wl) ? r_lim_m1[BIT_W-1:0] : '1;

    always_comb begin
        free_bit = '0;
        found    = 1'b0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word_data[b] && BIT_W'(b) >= lo_bit && BIT_W'(b) <= hi_bit) begin
                free_bit = BIT_W'(b);
                found    = 1'b1;
            end
        end
    end

    assign checking   = (r_state == ST_CK0) || (r_state == ST_CK1);
    assign word_new   = word_data | (WORD_BITS'(1) << free_bit);
    assign found_room = ROOM_W'({r_word, free_bit}) + ROOM_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && !reject) n_state = ST_RD0;
            end
            ST_RD0: n_state = ST_CK0;
            ST_CK0: begin
                if (!found && r_cand_ok) n_state = ST_RD1;
                else                     n_state = ST_IDLE;
            end
            ST_RD1: n_state = ST_CK1;
            ST_CK1: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_word;
        o_busy    = 1'b1;
        case (r_state)
            ST_IDLE: o_busy = 1'b0;
            ST_RD0,
            ST_RD1:  ram_re = 1'b1;
            ST_CK0,
            ST_CK1:  ram_we = found;
            default: o_busy = 1'b1;
        endcase
    end

    nfra_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_word),
        .i_wdata(word_new),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_room_count <= ROOM_CNT_RST;
            r_valid      <= '0;
            r_full       <= '0;
            r_res_stb    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_stb <= 1'b0;
            if (i_cfg_we) begin
                r_room_count <= i_cfg_wdata;
            end
            if (accept && reject) begin
                r_res_stb <= 1'b1;
            end
            if (checking && (found || r_state == ST_CK1 || !r_cand_ok)) begin
                r_res_stb <= 1'b1;
            end
            if (ram_we) begin
                r_valid[r_word] <= 1'b1;
                r_full[r_word]  <= &word_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= req1;
            r_limit <= lim;
            r_w0    <= req1_m1[BIT_W +: WW];
            r_wl    <= lim_m1[BIT_W +: WW];
            r_word  <= req1_m1[BIT_W +: WW];
            if (reject) begin
                r_res_room <= '0;
                r_res_none <= 1'b1;
            end
        end
        if (r_state == ST_RD0) begin
            r_cand    <= cand;
            r_cand_ok <= cand_ok;
        end
        if (checking) begin
            if (found) begin
                r_res_room <= found_room;
                r_res_none <= 1'b0;
            end else if (r_state == ST_CK0 && r_cand_ok) begin
                r_word <= r_cand;
            end else begin
                r_res_room <= '0;
                r_res_none <= 1'b1;
            end
        end
    end

    assign o_result_valid  = r_res_stb;
    assign o_assigned_room = r_res_room;
    assign o_none_free     = r_res_none;

    a_none_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_none_free == (o_assigned_room == '0)))
        else $error("none_free disagrees with assigned room");

    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_none_free) |->
            (o_assigned_room >= r_req && o_assigned_room <= r_limit))
        else $error("granted room outside request window");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_result_valid))
        else $error("accepted transaction dropped");

    a_write_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (o_result_valid && !o_none_free))
        else $error("map write without grant");

endmodule

// ----- verif/next_free_room_allocator_core_tb.sv -----
// Self-checking testbench for next_free_room_allocator_core: a directed table, then random
// phases at several room counts, every result checked against a typed expectation or an occupancy-map predictor.
// Depends on nfra_pkg and the core RTL (with its word RAM).
module next_free_room_allocator_core_tb;
    import nfra_pkg::*;

    localparam int ROOMS        = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_N      = 15;
    localparam int PHASE_ITEMS  = 130;
    localparam int DIR_N        = 24;
    localparam int EXP_DEPTH    = 16;
    localparam int EXP_W        = $clog2(EXP_DEPTH);

    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        t_room room;
        logic  none;
    } t_grant;

    typedef struct packed {
        logic  kind;
        t_room value;
        logic  chk;
        t_room room;
        logic  none;
    } t_row;

    // value is the request for an item row, the room count for a config row
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{ROW_ITEM, 11'd1,    CHK_TYPED, 11'd1,    1'b0},
        '{ROW_ITEM, 11'd1,    CHK_TYPED, 11'd2,    1'b0},
        '{ROW_ITEM, 11'd0,    CHK_TYPED, 11'd3,    1'b0},
        '{ROW_ITEM, 11'd1024, CHK_TYPED, 11'd1024, 1'b0},
        '{ROW_ITEM, 11'd1024, CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd2047, CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd1025, CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd1022, CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd1022, CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd1023, CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd31,   CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd32,   CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd31,   CHK_PRED,  11'd0,    1'b0},
        '{ROW_CFG,  11'd0,    CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd5,    CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd0,    CHK_TYPED, 11'd0,    1'b1},
        '{ROW_CFG,  11'd1,    CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd1,    CHK_TYPED, 11'd0,    1'b1},
        '{ROW_ITEM, 11'd2,    CHK_TYPED, 11'd0,    1'b1},
        '{ROW_CFG,  11'd2047, CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd1020, CHK_TYPED, 11'd1020, 1'b0},
        '{ROW_ITEM, 11'd1019, CHK_PRED,  11'd0,    1'b0},
        '{ROW_ITEM, 11'd1019, CHK_PRED,  11'd0,    1'b0},
        '{ROW_CFG,  11'd1024, CHK_PRED,  11'd0,    1'b0}
    };

    localparam t_room PHASE_COUNT [PHASE_N] = '{
        11'd0,   11'd64,  11'd1,    11'd130, 11'd2047,
        11'd250, 11'd400, 11'd1025, 11'd600, 11'd2,
        11'd800, 11'd1024, 11'd950, 11'd1536, 11'd1024
    };

    logic  i_clk            = 1'b0;
    logic  i_rst_n          = 1'b0;
    logic  i_start          = 1'b0;
    t_room i_requested_room = '0;
    logic  i_cfg_we         = 1'b0;
    t_room i_cfg_wdata      = '0;
    logic  o_busy;
    logic  o_result_valid;
    t_room o_assigned_room;
    logic  o_none_free;

    logic             occupied_q [ROOMS];
    t_room            room_count_q;
    t_grant           exp_mem [EXP_DEPTH];
    logic [EXP_W-1:0] exp_wr         = '0;
    logic [EXP_W-1:0] exp_rd         = '0;
    int               mismatch_count = 0;
    int               stall_cycles   = 0;

    next_free_room_allocator_core #(
        .ROOMS(ROOMS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_requested_room(i_requested_room),
        .o_result_valid  (o_result_valid),
        .o_assigned_room (o_assigned_room),
        .o_none_free     (o_none_free),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lowest free room at or above the request, within min(room_count, ROOMS); marks it taken.
    function automatic t_grant grant_room(input t_room req);
        int     lim;
        int     r;
        t_grant g;
        lim = (int'(room_count_q) < ROOMS) ? int'(room_count_q) : ROOMS;
        g.room = '0;
        g.none = 1'b1;
        for (r = (req == '0) ? 1 : int'(req); r <= lim; r++) begin
            if (!occupied_q[r-1]) begin
                occupied_q[r-1] = 1'b1;
                g.room = t_room'(r);
                g.none = 1'b0;
                break;
            end
        end
        return g;
    endfunction

    function automatic int pick_gap(input logic burst);
        int sel;
        sel = $urandom_range(0, 99);
        if (burst || sel < 60) begin
            return 0;
        end else if (sel < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction (plus gap).
    task automatic send_request(input t_room req, input int gap, input logic chk,
                                input t_grant typed);
        t_grant pred;
        i_start          <= 1'b1;
        i_requested_room <= req;
        do @(posedge i_clk); while (o_busy);
        pred = grant_room(req);
        exp_mem[exp_wr] = (chk == CHK_TYPED) ? typed : pred;
        exp_wr          = exp_wr + EXP_W'(1);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_room_count(input t_room value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        room_count_q  = value;
    endtask

    initial begin
        int    p;
        int    n;
        int    lim;
        int    sel;
        logic  burst;
        t_room req;
        for (n = 0; n < ROOMS; n++) occupied_q[n] = 1'b0;
        room_count_q = 11'd1024;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_N; n++) begin
            if (DIR_ROWS[n].kind == ROW_CFG) begin
                write_room_count(DIR_ROWS[n].value);
            end else begin
                send_request(DIR_ROWS[n].value, pick_gap(1'b0), DIR_ROWS[n].chk,
                             '{room: DIR_ROWS[n].room, none: DIR_ROWS[n].none});
            end
        end

        for (p = 0; p < PHASE_N; p++) begin
            write_room_count(PHASE_COUNT[p]);
            burst = ($urandom_range(0, 3) == 0);
            lim   = (int'(room_count_q) < ROOMS) ? int'(room_count_q) : ROOMS;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    req = t_room'($urandom_range(0, 2047));
                end else if (sel == 1) begin
                    req = '0;
                end else begin
                    req = t_room'($urandom_range(1, lim + 1));
                end
                send_request(req, pick_gap(burst), CHK_PRED, '0);
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("PASS next_free_room_allocator_core");
        end else begin
            $display("FAIL next_free_room_allocator_core");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_result_valid) begin
            if (exp_wr == exp_rd) begin
                if (mismatch_count < 10) begin
                    $display("mismatch: unexpected result room=%0d none_free=%0b",
                             o_assigned_room, o_none_free);
                end
                mismatch_count++;
            end else begin
                want   = exp_mem[exp_rd];
                exp_rd = exp_rd + EXP_W'(1);
                if (o_assigned_room !== want.room || o_none_free !== want.none) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: expected room=%0d none=%0b, got room=%0d none=%0b",
                                 want.room, want.none, o_assigned_room, o_none_free);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction, no result and no config write.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid || i_cfg_we || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL next_free_room_allocator_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
